FILE: hw/rtl/dmss_pkg.sv
package dmss_pkg;

  // block edge length
  localparam int LEVELS = 8;
  localparam int NDIAG  = 2 * LEVELS - 1;

  // field widths
  localparam int DIST_W = 9;
  localparam int BEST_W = 10;
  localparam int OFF_W  = 5;
  localparam int MAG_W  = 4;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BEST   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_OFFSET = 1'd1;

  localparam logic [BEST_W-1:0]       INITIAL_BEST_RST   = 10'd256;
  localparam logic signed [OFF_W-1:0] DEFAULT_OFFSET_RST = 5'sd0;

  // derived widths
  localparam int MAX_DIST = 256;
  localparam int SUM_W    = $clog2(LEVELS * MAX_DIST + 1);
  localparam int NUM_RAW  = $clog2(LEVELS * MAX_DIST + LEVELS);
  localparam int NUM_W    = (NUM_RAW > BEST_W) ? NUM_RAW : BEST_W;
  localparam int DIV_W    = $clog2(LEVELS + 1);
  localparam int RC_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DIAG_W   = (NDIAG > 1) ? $clog2(NDIAG) : 1;
  localparam int STEP_W   = $clog2(NUM_W);

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              block_end;
  } in_t;

  typedef struct packed {
    logic [BEST_W-1:0] best_score;
    logic [MAG_W-1:0]  first_scale_offset;
    logic [MAG_W-1:0]  second_scale_offset;
  } out_t;

endpackage

FILE: hw/rtl/diagonal_mean_scale_scorer_core.sv
// diagonal mean scale scorer
//
// in channel: a distance word is taken at a rising edge with start high and
// busy low. words arrive in row-major order of an LEVELS x LEVELS block, one
// per cycle while loading; block_end marks the last word of a block. words
// past LEVELS*LEVELS are dropped until block_end.
// after the block_end word, busy stays high while the diagonals are scanned
// in ascending offset through one shared restoring divider. each diagonal
// that holds data goes through setup, NUM_W divide steps and compare; an
// empty one goes through setup only. after the last diagonal the result is
// shown in the done state, then busy drops.
// out channel: the result word is shown for exactly one cycle with out_valid
// high; the receiver cannot stall, so nothing is held back.
// cfg channel: cfg_ready is always high; index 0 writes initial_best, index 1
// writes default_offset. write only while busy is low.
// reset (rst_n low, synchronous) clears the diagonal sums and load position
// and restores the register defaults (initial_best 256, default_offset 0).
module diagonal_mean_scale_scorer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  dmss_pkg::in_t                       in_word,
  output logic                                out_valid,
  output dmss_pkg::out_t                      out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dmss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dmss_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dmss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_DIV   = 5'b00100,
    S_CMP   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  localparam logic signed [OFF_W-1:0] D_FIRST = OFF_W'(-(LEVELS - 1));
  localparam logic signed [OFF_W-1:0] D_STEP  = OFF_W'(1);
  localparam logic [RC_W-1:0]         RC_LAST = RC_W'(LEVELS - 1);
  localparam logic [DIAG_W-1:0]       K_LAST  = DIAG_W'(NDIAG - 1);
  localparam logic [STEP_W-1:0]       STEP_LAST = STEP_W'(NUM_W - 1);

  state_t state_r;

  logic [BEST_W-1:0]       initial_best_r;
  logic signed [OFF_W-1:0] default_offset_r;

  logic [SUM_W-1:0]  sums_r [NDIAG];
  logic [NDIAG-1:0]  hit_r;
  logic [RC_W-1:0]   row_r;
  logic [RC_W-1:0]   col_r;
  logic              full_r;

  logic [DIAG_W-1:0]       k_r;
  logic signed [OFF_W-1:0] d_r;
  logic [BEST_W-1:0]       best_r;
  logic signed [OFF_W-1:0] off_r;

  logic [NUM_W-1:0]  quot_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  div_r;
  logic [STEP_W-1:0] step_r;

  logic              accept;
  logic [DIAG_W:0]   slot_wide;
  logic [DIAG_W-1:0] slot;
  logic [OFF_W-1:0]  mag;
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W:0]    trial;
  logic              trial_ge;
  logic [OFF_W-1:0]  neg_mag;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // diagonal slot = row - col + LEVELS - 1
  assign slot_wide = (DIAG_W+1)'(row_r) + (DIAG_W+1)'(LEVELS - 1) - (DIAG_W+1)'(col_r);
  assign slot      = slot_wide[DIAG_W-1:0];

  assign mag     = d_r[OFF_W-1] ? OFF_W'(-d_r) : OFF_W'(d_r);
  assign divisor = DIV_W'(LEVELS) - DIV_W'(mag);

  // restoring divide step
  assign trial    = {rem_r, quot_r[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, div_r});

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_best_r   <= INITIAL_BEST_RST;
      default_offset_r <= DEFAULT_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INITIAL_BEST:   initial_best_r   <= cfg_data[BEST_W-1:0];
        REG_DEFAULT_OFFSET: default_offset_r <= cfg_data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < NDIAG; i++) begin
        sums_r[i] <= '0;
      end
      hit_r  <= '0;
      row_r  <= '0;
      col_r  <= '0;
      full_r <= 1'b0;
      k_r    <= '0;
      d_r    <= D_FIRST;
      step_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (!full_r) begin
              sums_r[slot] <= sums_r[slot] + SUM_W'(in_word.distance);
              hit_r[slot]  <= 1'b1;
              if (col_r == RC_LAST) begin
                col_r <= '0;
                if (row_r == RC_LAST) begin
                  full_r <= 1'b1;
                end else begin
                  row_r <= row_r + 1'b1;
                end
              end else begin
                col_r <= col_r + 1'b1;
              end
            end
            if (in_word.block_end) begin
              k_r     <= '0;
              d_r     <= D_FIRST;
              best_r  <= initial_best_r;
              off_r   <= default_offset_r;
              state_r <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          if (hit_r[k_r]) begin
            // ceiling: divide sum + divisor - 1
            quot_r  <= NUM_W'(sums_r[k_r]) + NUM_W'(divisor) - NUM_W'(1);
            rem_r   <= '0;
            div_r   <= divisor;
            step_r  <= '0;
            state_r <= S_DIV;
          end else if (k_r == K_LAST) begin
            state_r <= S_DONE;
          end else begin
            k_r <= k_r + 1'b1;
            d_r <= d_r + D_STEP;
          end
        end
        S_DIV: begin
          rem_r  <= trial_ge ? DIV_W'(trial - {1'b0, div_r}) : trial[DIV_W-1:0];
          quot_r <= {quot_r[NUM_W-2:0], trial_ge};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (quot_r < NUM_W'(best_r)) begin
            best_r <= quot_r[BEST_W-1:0];
            off_r  <= d_r;
          end
          if (k_r == K_LAST) begin
            state_r <= S_DONE;
          end else begin
            k_r     <= k_r + 1'b1;
            d_r     <= d_r + D_STEP;
            state_r <= S_SETUP;
          end
        end
        S_DONE: begin
          for (int i = 0; i < NDIAG; i++) begin
            sums_r[i] <= '0;
          end
          hit_r   <= '0;
          row_r   <= '0;
          col_r   <= '0;
          full_r  <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // split the winning offset into its two magnitude fields
  assign neg_mag = OFF_W'(-off_r);

  always_comb begin
    out_valid                    = (state_r == S_DONE);
    out_word.best_score          = best_r;
    out_word.first_scale_offset  = '0;
    out_word.second_scale_offset = '0;
    if (off_r[OFF_W-1]) begin
      // -16 saturates to 15
      out_word.second_scale_offset = neg_mag[OFF_W-1] ? {MAG_W{1'b1}} : neg_mag[MAG_W-1:0];
    end else begin
      out_word.first_scale_offset = off_r[MAG_W-1:0];
    end
  end

endmodule

FILE: sim/diagonal_mean_scale_scorer_core_tb.sv
module diagonal_mean_scale_scorer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmss_pkg::*;

  localparam int NPOS           = LEVELS * LEVELS;
  localparam int SETTLE_CYCLES  = 230;   // longer than a full scan
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 900;
  localparam int MIN_BLOCKS     = 18;

  typedef enum int {SHAPE_NOISE, SHAPE_VALLEY, SHAPE_FLAT} shape_e;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_word;
  logic out_valid;
  out_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  diagonal_mean_scale_scorer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // scorer model state
  int unsigned diag_sum [NDIAG];
  int unsigned load_pos;
  logic [BEST_W-1:0] best_init;
  logic signed [OFF_W-1:0] dflt_off;

  out_t pending_scores[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit steady;

  function automatic void clear_diagonals();
    foreach (diag_sum[k]) diag_sum[k] = 0;
    load_pos = 0;
  endfunction

  // fold one accepted distance word into the diagonal sums, score on block_end
  function automatic void absorb_distance(input in_t w);
    int row, col, ofs, mag, first, div, score, best, win;
    out_t r;
    if (load_pos < NPOS) begin
      row = load_pos / LEVELS;
      col = load_pos % LEVELS;
      diag_sum[row - col + LEVELS - 1] += w.distance;
      load_pos++;
    end
    if (w.block_end) begin
      best = best_init;
      win = dflt_off;
      for (ofs = -(LEVELS - 1); ofs <= LEVELS - 1; ofs++) begin
        mag = (ofs < 0) ? -ofs : ofs;
        first = (ofs >= 0) ? ofs * LEVELS : mag;
        div = LEVELS - mag;
        // diagonals that got no distance in a short block are skipped
        if (first < load_pos) begin
          score = (diag_sum[ofs + LEVELS - 1] + div - 1) / div;
          if (score < best) begin
            best = score;
            win = ofs;
          end
        end
      end
      r = '0;
      r.best_score = BEST_W'(best);
      if (win < 0) r.second_scale_offset = MAG_W'((-win > 15) ? 15 : -win);
      else r.first_scale_offset = MAG_W'((win > 15) ? 15 : win);
      pending_scores = {pending_scores, r};
      clear_diagonals();
    end
  endfunction

  function automatic in_t mk_word(input int dval, input bit last);
    in_t w;
    w.distance = DIST_W'(dval);
    w.block_end = last;
    return w;
  endfunction

  task automatic report(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_scores
    out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_scores.size() == 0) begin
        mismatch_count++;
        $display("%0t: score word expected none actual %0d/%0d/%0d", $time,
                 out_word.best_score, out_word.first_scale_offset,
                 out_word.second_scale_offset);
      end else begin
        want = pending_scores.pop_front();
        report("best_score", want.best_score, out_word.best_score);
        report("first_scale_offset", want.first_scale_offset, out_word.first_scale_offset);
        report("second_scale_offset", want.second_scale_offset,
               out_word.second_scale_offset);
      end
    end
  end

  // cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1 || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_word(input in_t w);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 38) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      in_word.distance <= DIST_W'($urandom);
      in_word.block_end <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    absorb_distance(w);
  endtask

  // drop start and wait until every score word is back and the scan is over
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_INITIAL_BEST:   best_init = data[BEST_W-1:0];
      REG_DEFAULT_OFFSET: dflt_off = data[OFF_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [BEST_W-1:0] best, input logic [OFF_W-1:0] off);
    logic [CFG_DATA_W-1:0] off_word;
    off_word = CFG_DATA_W'($urandom);   // upper bits are don't-care
    off_word[OFF_W-1:0] = off;
    settle();
    if ($urandom_range(1)) begin
      write_reg(REG_INITIAL_BEST, best);
      write_reg(REG_DEFAULT_OFFSET, off_word);
    end else begin
      write_reg(REG_DEFAULT_OFFSET, off_word);
      write_reg(REG_INITIAL_BEST, best);
    end
  endtask

  task automatic send_block(input int len, input shape_e shape);
    int valley, flat, row, col, dval;
    valley = $urandom_range(NDIAG - 1);
    flat = $urandom_range(256);
    for (int i = 0; i < len; i++) begin
      row = (i % NPOS) / LEVELS;
      col = i % LEVELS;
      case (shape)
        SHAPE_FLAT: dval = flat;
        SHAPE_VALLEY: begin
          if (row - col + LEVELS - 1 == valley) dval = $urandom_range(40);
          else dval = $urandom_range(90, 256);
        end
        default: begin
          case ($urandom_range(9))
            0: dval = 0;
            1: dval = 256;
            default: dval = $urandom_range(256);
          endcase
        end
      endcase
      send_word(mk_word(dval, i == len - 1));
    end
  endtask

  // reset values, single-word short blocks at both distance extremes
  task automatic test_reset_defaults();
    send_word(mk_word(256, 1'b1));
    send_word(mk_word(0, 1'b1));
  endtask

  task automatic test_diagonal_winners();
    // lower diagonal wins: row 0 full of 256, then a zero at row 1 col 0
    for (int i = 0; i < LEVELS; i++) send_word(mk_word(256, 1'b0));
    send_word(mk_word(0, 1'b1));
    // first upper diagonal wins
    send_word(mk_word(256, 1'b0));
    send_word(mk_word(0, 1'b1));
    // corner diagonal with a divisor of one wins
    for (int i = 0; i < LEVELS - 1; i++) send_word(mk_word(256, 1'b0));
    send_word(mk_word(0, 1'b1));
  endtask

  task automatic test_default_offset();
    // nothing beats a best of zero; the most negative offset saturates
    set_config('0, OFF_W'(-16));
    send_word(mk_word(0, 1'b1));
    set_config('0, OFF_W'(15));
    send_word(mk_word(256, 1'b1));
    set_config(10'd1023, OFF_W'(-15));
    send_word(mk_word(256, 1'b1));
  endtask

  task automatic test_overlong_blocks();
    // words past the full block are dropped, so the 256s must not count
    for (int i = 0; i < NPOS; i++) send_word(mk_word(0, 1'b0));
    for (int i = 0; i < 6; i++) send_word(mk_word(256, i == 5));
    // flat full block: all means tie, the first diagonal keeps the win
    for (int i = 0; i < NPOS; i++) send_word(mk_word(256, i == NPOS - 1));
    send_block($urandom_range(NPOS + 1, NPOS + 8), SHAPE_NOISE);
  endtask

  task automatic test_random_blocks();
    int blocks, words, len, pick;
    logic [BEST_W-1:0] best;
    blocks = 0;
    words = 0;
    while (words < RANDOM_WORDS || blocks < MIN_BLOCKS) begin
      if (blocks % 6 == 0) begin
        case ($urandom_range(5))
          0: best = '0;
          1: best = '1;
          2, 3: best = BEST_W'($urandom_range(1023));
          default: best = BEST_W'($urandom_range(20, 200));
        endcase
        set_config(best, OFF_W'($urandom_range(31)));
        // one phase runs back to back with no gaps
        steady = (blocks / 6 == 2);
      end
      pick = $urandom_range(99);
      if (pick < 40) len = NPOS;
      else if (pick < 85) len = $urandom_range(1, NPOS - 1);
      else len = $urandom_range(NPOS + 1, NPOS + 8);
      send_block(len, shape_e'($urandom_range(2)));
      words += len;
      blocks++;
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    best_init = INITIAL_BEST_RST;
    dflt_off = DEFAULT_OFFSET_RST;
    clear_diagonals();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_diagonal_winners();
    test_default_offset();
    test_overlong_blocks();
    test_random_blocks();

    settle();
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
